### design/rmie_pkg.sv
// ----------------------------------------------------------------------------
// rmie_pkg
// Shared constants for the random access machine executor.
// ----------------------------------------------------------------------------
package rmie_pkg;

  localparam int RegistersDefault = 256;
  localparam int DataWidthDefault = 32;
  localparam int ProgIdxWidthDefault = 16;

  localparam logic [3:0] OP_READ  = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_STORE = 4'd2;
  localparam logic [3:0] OP_WRITE = 4'd3;
  localparam logic [3:0] OP_ADD   = 4'd4;
  localparam logic [3:0] OP_SUB   = 4'd5;
  localparam logic [3:0] OP_MUL   = 4'd6;
  localparam logic [3:0] OP_DIV   = 4'd7;
  localparam logic [3:0] OP_JUMP  = 4'd8;
  localparam logic [3:0] OP_JZERO = 4'd9;
  localparam logic [3:0] OP_JGTZ  = 4'd10;

  localparam logic [1:0] MODE_IMM  = 2'd0;
  localparam logic [1:0] MODE_DIR  = 2'd1;
  localparam logic [1:0] MODE_IND  = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_ILLEGAL = 2'd1;
  localparam logic [1:0] ERR_DIVZERO = 2'd2;
  localparam logic [1:0] ERR_RANGE   = 2'd3;

endpackage

### design/rmie_ram.sv
// ----------------------------------------------------------------------------
// rmie_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rmie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### design/rmie_div.sv
// ----------------------------------------------------------------------------
// rmie_div
// Signed restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module rmie_div import rmie_pkg::*; #(
  parameter int DW = DataWidthDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] count;
  logic [DW-1:0] rem;
  logic [DW-1:0] quo;
  logic [DW-1:0] dsr;
  logic          neg;
  logic [DW:0]   trial;

  assign trial = {rem, quo[DW-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CW'(DW);
        rem <= '0;
        quo <= dividend[DW-1] ? -dividend : dividend;
        dsr <= divisor[DW-1] ? -divisor : divisor;
        neg <= dividend[DW-1] ^ divisor[DW-1];
      end else if (busy) begin
        if (!trial[DW]) begin
          rem <= trial[DW-1:0];
          quo <= {quo[DW-2:0], 1'b1};
        end else begin
          rem <= {rem[DW-2:0], quo[DW-1]};
          quo <= {quo[DW-2:0], 1'b0};
        end
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -quo : quo;
endmodule

### design/ram_machine_instruction_execute.sv
// ----------------------------------------------------------------------------
// ram_machine_instruction_execute
// Executes one random access machine instruction per input word.
//
// Input word on s_axis: operation, mode, operand, jump target, tape value.
// Output word on m_axis: write flag/value, branch flag/target, error code
// and the accumulator after the instruction. One result per instruction.
// The register file is a single-port RAM; register 0 is the accumulator,
// mirrored in a flop. Jumps and words rejected at decode are answered from
// S_IDLE; immediate runs S_EXEC, direct S_OPND then S_EXEC, indirect S_PTR,
// S_OPND, S_EXEC (pointer read then operand read, one RAM access each), and
// div adds S_DIV. One instruction is in flight at a time.
// After reset a clearing pass zeroes every register of the file, with
// s_axis_tready low. A stalled result holds in the output register and
// blocks the next instruction until it is taken.
// ----------------------------------------------------------------------------
module ram_machine_instruction_execute import rmie_pkg::*; #(
  parameter int REGISTERS = RegistersDefault,
  parameter int DATA_WIDTH = DataWidthDefault,
  parameter int PROGRAM_INDEX_WIDTH = ProgIdxWidthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation[3:0], mode[5:4], operand[37:6], jump_target[53:38], tape_value[85:54]
  input  logic [87:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // write_valid[0], write_value[32:1], branch_taken[33], branch_target[49:34],
  // error_code[51:50], accumulator[83:52]
  output logic [87:0]  m_axis_tdata
);
  localparam int AW = $clog2(REGISTERS);
  localparam int DW = DATA_WIDTH;
  localparam int PW = PROGRAM_INDEX_WIDTH;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_PTR   = 6'b000100,
    S_OPND  = 6'b001000,
    S_EXEC  = 6'b010000,
    S_DIV   = 6'b100000
  } state_t;

  state_t        state;
  logic [AW:0]   clr_cnt;
  logic [3:0]    op;
  logic [1:0]    mode;
  logic [31:0]   opnd;
  logic [31:0]   tape;
  logic [DW-1:0] acc;
  logic [AW-1:0] idx;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [DW-1:0] ram_wdata;
  logic [DW-1:0] ram_rdata;
  logic          div_start;
  logic          div_done;
  logic [DW-1:0] div_q;
  logic [DW-1:0] val;
  logic          out_valid;
  logic [87:0]   out_data;

  logic [3:0]    in_op;
  logic [1:0]    in_mode;
  logic [31:0]   in_opnd;
  logic          in_opnd_ok;
  logic          ptr_ok;
  logic [DW-1:0] imm_ext;
  logic [DW-1:0] tape_ext;

  assign in_op   = s_axis_tdata[3:0];
  assign in_mode = s_axis_tdata[5:4];
  assign in_opnd = s_axis_tdata[37:6];
  assign in_opnd_ok = !in_opnd[31] && ({1'b0, in_opnd} < 33'(REGISTERS));
  assign ptr_ok = !ram_rdata[DW-1] &&
                  ({1'b0, ram_rdata} < (DW+1)'(REGISTERS));
  assign imm_ext = DW'($signed(opnd));
  assign tape_ext = DW'($signed(tape));

  rmie_ram #(.WIDTH(DW), .DEPTH(REGISTERS)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  rmie_div #(.DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(acc), .divisor(val),
    .done(div_done), .quotient(div_q)
  );

  assign s_axis_tready = (state == S_IDLE) && !out_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign val = (mode == MODE_IMM) ? imm_ext : ram_rdata;

  always_comb begin
    ram_we = 1'b0;
    ram_addr = idx;
    ram_wdata = tape_ext;
    div_start = 1'b0;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_cnt[AW-1:0];
        ram_wdata = '0;
      end
      S_IDLE: ram_addr = in_opnd[AW-1:0];
      S_PTR: ram_addr = ram_rdata[AW-1:0];
      S_EXEC: begin
        if (op == OP_READ) begin
          ram_we = 1'b1;
        end else if (op == OP_STORE) begin
          ram_we = 1'b1;
          ram_wdata = acc;
        end else if (op == OP_DIV && val != '0) begin
          div_start = 1'b1;
        end
        ram_addr = idx;
        if (op == OP_ADD || op == OP_SUB || op == OP_MUL || op == OP_LOAD) begin
          ram_we = 1'b1;
          ram_addr = '0;
          case (op)
            OP_LOAD: ram_wdata = val;
            OP_ADD:  ram_wdata = acc + val;
            OP_SUB:  ram_wdata = acc - val;
            default: ram_wdata = acc * val;
          endcase
        end
      end
      S_DIV: begin
        ram_we = div_done;
        ram_addr = '0;
        ram_wdata = div_q;
      end
      default: ;
    endcase
  end

  function automatic logic [87:0] pack(input logic wv, input logic [31:0] wval,
                                       input logic bt, input logic [15:0] btg,
                                       input logic [1:0] err, input logic [31:0] a);
    pack = {4'd0, a, err, btg, bt, wval, wv};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      acc <= '0;
    end else begin
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + (AW+1)'(1);
          if (clr_cnt == (AW+1)'(REGISTERS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            op <= in_op;
            mode <= in_mode;
            opnd <= in_opnd;
            tape <= s_axis_tdata[85:54];
            idx <= in_opnd[AW-1:0];
            if (in_op > OP_JGTZ) begin
              out_valid <= 1'b1;
              out_data <= pack(1'b0, '0, 1'b0, '0, ERR_ILLEGAL, 32'(acc));
            end else if (in_op >= OP_JUMP) begin
              out_valid <= 1'b1;
              if (in_op == OP_JUMP || (in_op == OP_JZERO && acc == '0) ||
                  (in_op == OP_JGTZ && acc != '0 && !acc[DW-1])) begin
                out_data <= pack(1'b0, '0, 1'b1,
                                 16'(s_axis_tdata[38 +: PW]), ERR_OK, 32'(acc));
              end else begin
                out_data <= pack(1'b0, '0, 1'b0, '0, ERR_OK, 32'(acc));
              end
            end else if (in_mode == MODE_RSVD ||
                         (in_mode == MODE_IMM &&
                          (in_op == OP_READ || in_op == OP_STORE)) ||
                         (in_mode != MODE_IMM && in_op == OP_WRITE &&
                          in_opnd == '0)) begin
              out_valid <= 1'b1;
              out_data <= pack(1'b0, '0, 1'b0, '0, ERR_ILLEGAL, 32'(acc));
            end else if (in_mode == MODE_IMM) begin
              state <= S_EXEC;
            end else if (!in_opnd_ok) begin
              out_valid <= 1'b1;
              out_data <= pack(1'b0, '0, 1'b0, '0, ERR_RANGE, 32'(acc));
            end else if (in_mode == MODE_DIR) begin
              state <= S_OPND;
            end else begin
              state <= S_PTR;
            end
          end
        end
        S_PTR: begin
          if (!ptr_ok) begin
            out_valid <= 1'b1;
            out_data <= pack(1'b0, '0, 1'b0, '0, ERR_RANGE, 32'(acc));
            state <= S_IDLE;
          end else begin
            idx <= ram_rdata[AW-1:0];
            state <= S_OPND;
          end
        end
        S_OPND: state <= S_EXEC;
        S_EXEC: begin
          state <= S_IDLE;
          out_valid <= 1'b1;
          out_data <= pack(1'b0, '0, 1'b0, '0, ERR_OK, 32'(acc));
          case (op)
            OP_READ: begin
              if (idx == '0) begin
                acc <= tape_ext;
                out_data <= pack(1'b0, '0, 1'b0, '0, ERR_OK, 32'(tape_ext));
              end
            end
            OP_WRITE: out_data <= pack(1'b1, 32'(val), 1'b0, '0, ERR_OK, 32'(acc));
            OP_LOAD, OP_ADD, OP_SUB, OP_MUL: begin
              acc <= ram_wdata;
              out_data <= pack(1'b0, '0, 1'b0, '0, ERR_OK, 32'(ram_wdata));
            end
            OP_DIV: begin
              if (val == '0) begin
                out_data <= pack(1'b0, '0, 1'b0, '0, ERR_DIVZERO, 32'(acc));
              end else begin
                out_valid <= 1'b0;
                state <= S_DIV;
              end
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            acc <= div_q;
            out_valid <= 1'b1;
            out_data <= pack(1'b0, '0, 1'b0, '0, ERR_OK, 32'(div_q));
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) s_axis_tready |-> state == S_IDLE)
    else $error("ready outside idle");
  assert property (@(posedge clk) disable iff (rst) (state == S_CLEAR) |-> !out_valid)
    else $error("result during clear");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data[51:50] != ERR_OK) |-> !out_data[33] && !out_data[0])
    else $error("error result with side effect");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> !out_valid)
    else $error("result while dividing");
endmodule

### tb/sv/ram_machine_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ram_machine_checker
// Watches both streams of the random access machine executor, runs its own
// register file model on every accepted instruction word and compares each
// result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ram_machine_checker import rmie_pkg::*; #(
  parameter int REGISTERS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [87:0] m_axis_tdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] accumulator;
    logic [1:0]  error_code;
    logic [15:0] branch_target;
    logic        branch_taken;
    logic [31:0] write_value;
    logic        write_valid;
  } outcome_t;

  logic [31:0] regs [REGISTERS];
  outcome_t    outcome_q [$];

  function automatic logic [1:0] pick_reg(input logic [31:0] v, output int idx);
    idx = 0;
    if (v[31] || v >= REGISTERS) return ERR_RANGE;
    idx = int'(v);
    return ERR_OK;
  endfunction

  function automatic logic [31:0] quotient(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  task automatic execute(input logic [87:0] w);
    logic [3:0]  op;
    logic [1:0]  md;
    logic [31:0] opnd, tape, acc, val, nacc;
    logic [15:0] tgt;
    logic [1:0]  err;
    logic        setacc;
    int          idx, first;
    outcome_t    o;
    op = w[3:0]; md = w[5:4]; opnd = w[37:6]; tgt = w[53:38]; tape = w[85:54];
    acc = regs[0]; val = '0; err = ERR_OK; setacc = 0; idx = 0; o = '0;
    if (op > OP_JGTZ) err = ERR_ILLEGAL;
    else if (op <= OP_DIV) begin
      if (md == MODE_RSVD) err = ERR_ILLEGAL;
      else if (md == MODE_IMM) begin
        if (op == OP_READ || op == OP_STORE) err = ERR_ILLEGAL;
        val = opnd;
      end else if (op == OP_WRITE && opnd == 0) err = ERR_ILLEGAL;
      else begin
        err = pick_reg(opnd, first);
        idx = first;
        if (err == ERR_OK && md == MODE_IND) err = pick_reg(regs[first], idx);
        if (err == ERR_OK) val = regs[idx];
      end
    end
    nacc = acc;
    if (err == ERR_OK) begin
      case (op)
        OP_READ:  regs[idx] = tape;
        OP_LOAD:  begin nacc = val; setacc = 1; end
        OP_STORE: regs[idx] = acc;
        OP_WRITE: begin o.write_valid = 1; o.write_value = val; end
        OP_ADD:   begin nacc = acc + val; setacc = 1; end
        OP_SUB:   begin nacc = acc - val; setacc = 1; end
        OP_MUL:   begin nacc = acc * val; setacc = 1; end
        OP_DIV:
          if (val == 0) err = ERR_DIVZERO;
          else begin nacc = quotient(acc, val); setacc = 1; end
        OP_JUMP:  o.branch_taken = 1;
        OP_JZERO: o.branch_taken = (acc == 0);
        default:  o.branch_taken = (acc != 0) && !acc[31];
      endcase
    end
    if (err == ERR_OK && setacc) regs[0] = nacc;
    if (err != ERR_OK) o = '0;
    o.branch_target = o.branch_taken ? tgt : 16'd0;
    o.error_code = err;
    o.accumulator = regs[0];
    outcome_q.push_back(o);
  endtask

  always @(posedge clk) begin
    outcome_t got, want;
    if (rst) begin
      foreach (regs[i]) regs[i] = '0;
      outcome_q.delete();
      fail_count <= 0;
      pending = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[83:0];
        if (outcome_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = outcome_q.pop_front();
          if (got !== want || m_axis_tdata[87:84] !== 4'd0) begin
            if (fail_count < 10)
              $display("result differs: wv %b/%b wval %h/%h bt %b/%b tgt %h/%h err %0d/%0d acc %h/%h",
                       want.write_valid, got.write_valid, want.write_value, got.write_value,
                       want.branch_taken, got.branch_taken, want.branch_target,
                       got.branch_target, want.error_code, got.error_code,
                       want.accumulator, got.accumulator);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) execute(s_axis_tdata);
      pending = outcome_q.size();
    end
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random instruction words into the executor with
// varied idling on both streams; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import rmie_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [87:0] m_axis_tdata;
  int          fail_count, pending;
  int          send_idle = 22, recv_idle = 59;
  bit          hold_off = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  ram_machine_instruction_execute u_dut (.*);

  ram_machine_checker u_chk (.*);

  always @(negedge clk)
    m_axis_tready <= !rst && !hold_off && ($urandom_range(99) >= recv_idle);

  task automatic send_word(input logic [3:0] op, input logic [1:0] md,
                           input logic [31:0] opnd, input logic [15:0] tgt,
                           input logic [31:0] tape);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tdata <= {2'b00, tape, tgt, opnd, md, op};
    s_axis_tvalid <= 1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom_range(15);
      1: return -$urandom_range(8);
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_regnum();
    case ($urandom_range(9))
      0: return 256 + $urandom_range(3);
      1: return $urandom;
      2: return -1;
      3: return 255;
      default: return $urandom_range(15);
    endcase
  endfunction

  task automatic random_word();
    logic [3:0]  op;
    logic [1:0]  md;
    logic [31:0] opnd;
    op = ($urandom_range(19) == 0) ? 4'(11 + $urandom_range(4)) : 4'($urandom_range(10));
    md = ($urandom_range(19) == 0) ? MODE_RSVD : 2'($urandom_range(2));
    opnd = (md == MODE_IMM) ? pick_value() : pick_regnum();
    send_word(op, md, opnd, 16'($urandom), pick_value());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 0;
    send_word(OP_READ, MODE_IMM, 5, 0, 7);
    send_word(OP_READ, MODE_DIR, 1, 0, 32'h8000_0000);
    send_word(OP_READ, MODE_DIR, 2, 0, 3);
    send_word(OP_READ, MODE_DIR, 3, 0, -1);
    send_word(OP_READ, MODE_DIR, 4, 0, 256);
    send_word(OP_READ, MODE_IND, 2, 0, 32'h7fff_ffff);
    send_word(OP_LOAD, MODE_IND, 3, 0, 0);
    send_word(OP_LOAD, MODE_IND, 4, 0, 0);
    send_word(OP_LOAD, MODE_DIR, 1, 0, 0);
    send_word(OP_DIV, MODE_IMM, -1, 0, 0);
    send_word(OP_DIV, MODE_DIR, 9, 0, 0);
    send_word(OP_STORE, MODE_IMM, 1, 0, 0);
    send_word(OP_STORE, MODE_IND, 2, 0, 0);
    send_word(OP_WRITE, MODE_DIR, 0, 0, 0);
    send_word(OP_WRITE, MODE_IMM, 0, 0, 0);
    send_word(OP_WRITE, MODE_IND, 3, 0, 0);
    send_word(OP_ADD, MODE_DIR, 256, 0, 0);
    send_word(OP_SUB, MODE_DIR, -1, 0, 0);
    send_word(OP_MUL, MODE_IMM, 32'hffff_ffff, 0, 0);
    send_word(OP_JUMP, MODE_IMM, 0, 16'hffff, 0);
    send_word(OP_JGTZ, MODE_DIR, 0, 16'h1234, 0);
    send_word(OP_LOAD, MODE_IMM, 0, 0, 0);
    send_word(OP_JZERO, MODE_IMM, 0, 16'hffff, 0);
    send_word(4'd15, MODE_RSVD, 0, 0, 0);
    send_word(OP_ADD, MODE_RSVD, 1, 0, 0);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 22 : (phase == 1) ? 59 : 0;
      recv_idle = (phase == 0) ? 59 : (phase == 1) ? 22 : 0;
      for (int n = 0; n < 500; n++) random_word();
      s_axis_tvalid <= 0;
      while (pending != 0) @(negedge clk);
    end
    fork
      begin
        hold_off = 1;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      for (int n = 0; n < 20; n++) random_word();
    join
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("ram_machine_instruction_execute: match");
    else $display("ram_machine_instruction_execute: mismatch");
    $finish;
  end

  initial begin
    #20ms;
    $display("ram_machine_instruction_execute: mismatch");
    $finish;
  end

endmodule
